### hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants and types for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int          CAPACITY_MAX_DEF = 16;
  localparam int          CAP_W            = 5;
  localparam int          WORD_W           = 32;
  localparam logic [4:0]  CAP_RESET        = 5'd16;
  localparam logic [31:0] MISS_VALUE       = 32'hFFFF_FFFF;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } lkv_state_t;

endpackage

### hdl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least recently used replacement.
// ----------------------------------------------------------------------------
//  channel   | handshake            | words
//  ----------+----------------------+-------------------------------
//  request   | start, busy          | opcode, key, value
//  result    | result_strobe        | found, read_value
//  config    | cfg_we               | cfg_wdata (capacity in use)
//
//  A request holds busy high through one pass of the shared key comparator over
//  every RAM entry, a decision state, then a second pass that ages recency ranks
//  through the same RAM port. A get that misses ends after the decision state.
//  The next request is taken in the idle cycle that follows. The result strobe
//  is high for one cycle; the receiver cannot stall it. Reset clears the valid
//  flags at once, no sweep is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int CAPACITY_MAX = lkv_pkg::CAPACITY_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic signed [lkv_pkg::WORD_W-1:0] key,
  input  logic signed [lkv_pkg::WORD_W-1:0] value,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                        result_strobe,
  output logic                        found,
  output logic signed [lkv_pkg::WORD_W-1:0] read_value
);

  import lkv_pkg::*;

  localparam int IW = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
  localparam int CW = $clog2(CAPACITY_MAX + 1);
  localparam int RW = IW;
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int RAM_W = 2 * WORD_W + RW;
  localparam logic [CW-1:0] CAP_LAST = CW'(CAPACITY_MAX);
  localparam logic [EW-1:0] CAP_EXT  = EW'(CAPACITY_MAX);

  lkv_state_t state, state_next;

  logic [CAP_W-1:0]        cap_reg;
  logic [CW-1:0]           fill_count;
  logic [CAPACITY_MAX-1:0] valid;

  logic                    op_put;
  logic [WORD_W-1:0]       req_key;
  logic [WORD_W-1:0]       req_value;

  logic [CW-1:0]           cnt;
  logic                    pv;
  logic [IW-1:0]           pidx;

  logic                    hit_f, free_f, vic_f;
  logic [IW-1:0]           hit_idx, free_idx, vic_idx;
  logic [RW-1:0]           hit_rank, vic_rank;
  logic [WORD_W-1:0]       hit_data;

  logic [IW-1:0]           slot;
  logic [CW-1:0]           old_thr;

  // RAM word: key, data, rank
  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [RAM_W-1:0]        ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [RAM_W-1:0]        ram_rdata;
  logic [WORD_W-1:0]       rd_key, rd_data;
  logic [RW-1:0]           rd_rank;
  logic                    rd_valid;

  logic [EW-1:0]           cap_ext, eff_cap;
  logic                    fill_lt;

  logic                    issue;
  logic                    pass_done;
  logic                    act_update, act_fill;
  logic [IW-1:0]           act_slot;
  logic [CW-1:0]           act_old;

  assign rd_key   = ram_rdata[RAM_W-1 -: WORD_W];
  assign rd_data  = ram_rdata[RW +: WORD_W];
  assign rd_rank  = ram_rdata[RW-1:0];
  assign rd_valid = valid[pidx];

  assign cap_ext = EW'(cap_reg);
  assign eff_cap = (cap_ext == '0) ? EW'(1) : ((cap_ext > CAP_EXT) ? CAP_EXT : cap_ext);
  assign fill_lt = EW'(fill_count) < eff_cap;

  assign busy      = (state != ST_IDLE);
  assign issue     = (cnt != CAP_LAST);
  assign pass_done = !issue && !pv;
  assign ram_raddr = cnt[IW-1:0];

  lkv_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CAPACITY_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decision on the scan results
  always_comb begin
    act_update = 1'b0;
    act_fill   = 1'b0;
    act_slot   = hit_idx;
    act_old    = CW'(hit_rank);
    if (hit_f) begin
      act_update = 1'b1;
    end else if (op_put) begin
      if (fill_lt) begin
        act_update = free_f;
        act_fill   = free_f;
        act_slot   = free_idx;
        act_old    = fill_count + CW'(1);
      end else begin
        act_update = vic_f;
        act_slot   = vic_idx;
        act_old    = CW'(vic_rank);
      end
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = pidx;
    ram_wdata  = {rd_key, rd_data, rd_rank + RW'(1)};
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pass_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // slot becomes most recent; put carries the new value
        ram_we     = act_update;
        ram_waddr  = act_slot;
        ram_wdata  = {req_key, (op_put ? req_value : hit_data), {RW{1'b0}}};
        state_next = act_update ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: begin
        // age valid entries younger than the old rank
        ram_we = pv && (pidx != slot) && rd_valid && (CW'(rd_rank) < old_thr);
        if (pass_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg       <= CAP_RESET;
      fill_count    <= '0;
      valid         <= '0;
      result_strobe <= 1'b0;
      cnt           <= '0;
      pv            <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          pv  <= 1'b0;
        end
        ST_SCAN, ST_UPDATE: begin
          pv <= issue;
          if (issue) begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_DECIDE: begin
          cnt           <= '0;
          pv            <= 1'b0;
          result_strobe <= !op_put;
          if (act_update) begin
            valid[act_slot] <= 1'b1;
          end
          if (act_fill) begin
            fill_count <= fill_count + CW'(1);
          end
        end
        default: begin
          cnt <= '0;
          pv  <= 1'b0;
        end
      endcase
    end
  end

  // Payload and scan bookkeeping
  always_ff @(posedge clk) begin
    pidx <= cnt[IW-1:0];
    if (state == ST_IDLE && start) begin
      op_put    <= (opcode == OP_PUT);
      req_key   <= key;
      req_value <= value;
      hit_f     <= 1'b0;
      free_f    <= 1'b0;
      vic_f     <= 1'b0;
    end
    if (state == ST_SCAN && pv) begin
      if (rd_valid && rd_key == req_key && !hit_f) begin
        hit_f    <= 1'b1;
        hit_idx  <= pidx;
        hit_rank <= rd_rank;
        hit_data <= rd_data;
      end
      if (!rd_valid && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= pidx;
      end
      if (rd_valid && (!vic_f || rd_rank > vic_rank)) begin
        vic_f    <= 1'b1;
        vic_idx  <= pidx;
        vic_rank <= rd_rank;
      end
    end
    if (state == ST_DECIDE) begin
      slot       <= act_slot;
      old_thr    <= act_old;
      found      <= hit_f;
      read_value <= hit_f ? hit_data : MISS_VALUE;
    end
  end

endmodule

### test/tb_lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key/value cache. A mirror of the cache
// tracks keys, values and recency ranks; every get predicts found/read_value,
// and each result strobe is checked against the oldest pending answer.
// Directed corner cases come first, then random phases at several capacities.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
  import lkv_pkg::*;

  localparam int SLOTS       = CAPACITY_MAX_DEF;
  localparam int SETTLE      = 2 * SLOTS + 3 + 12;
  localparam int MAX_GAP     = 2 * SLOTS + 8;
  localparam int PHASE_ITEMS = 175;
  localparam int CYCLE_LIMIT = 600_000;

  class lru_mirror;
    logic [WORD_W-1:0] slot_key [SLOTS];
    logic [WORD_W-1:0] slot_data[SLOTS];
    bit                slot_used[SLOTS];
    int unsigned       slot_age [SLOTS];
    int unsigned       fill;
    logic [CAP_W-1:0]  capacity;
    logic              answer_found[$];
    logic [WORD_W-1:0] answer_value[$];
    int unsigned       errors, gets, hits, puts, evictions;

    function new();
      fill      = 0;
      capacity  = CAP_RESET;
      errors    = 0;
      gets      = 0;
      hits      = 0;
      puts      = 0;
      evictions = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
        slot_key[i]  = '0;
        slot_data[i] = '0;
      end
    endfunction

    function int unsigned usable();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
    endfunction

    function int pending();
      return answer_found.size();
    endfunction

    // Make slot most recent; valid entries younger than its old rank age by one.
    function void promote(int s, int unsigned old_age);
      for (int i = 0; i < SLOTS; i++) begin
        if (i != s && slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
      end
      slot_age[s] = 0;
    endfunction

    function int find(logic [WORD_W-1:0] k);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    function void note_request(logic op, logic [WORD_W-1:0] k, logic [WORD_W-1:0] v);
      int          hit;
      int          victim;
      int unsigned worst;
      hit = find(k);
      if (op == OP_GET) begin
        gets++;
        if (hit >= 0) begin
          hits++;
          answer_found.push_back(1'b1);
          answer_value.push_back(slot_data[hit]);
          promote(hit, slot_age[hit]);
        end else begin
          answer_found.push_back(1'b0);
          answer_value.push_back(MISS_VALUE);
        end
        return;
      end
      puts++;
      if (hit >= 0) begin
        slot_data[hit] = v;
        promote(hit, slot_age[hit]);
        return;
      end
      if (fill < usable()) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_key[i]  = k;
            slot_data[i] = v;
            promote(i, fill + 1);
            fill++;
            return;
          end
        end
        return;
      end
      // Full (or capacity lowered below fill): replace the least recent entry.
      victim = -1;
      worst  = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && (victim < 0 || slot_age[i] > worst)) begin
          worst  = slot_age[i];
          victim = i;
        end
      end
      if (victim < 0) return;
      evictions++;
      slot_key[victim]  = k;
      slot_data[victim] = v;
      promote(victim, worst);
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_answer(logic f, logic [WORD_W-1:0] v);
      logic              exp_f;
      logic [WORD_W-1:0] exp_v;
      if (answer_found.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: found=%0b read_value=%h",
                                  f, v));
        return;
      end
      exp_f = answer_found.pop_front();
      exp_v = answer_value.pop_front();
      if (f !== exp_f)
        report_mismatch($sformatf("found %0b, expected %0b", f, exp_f));
      if (v !== exp_v)
        report_mismatch($sformatf("read_value %h, expected %h", v, exp_v));
    endtask
  endclass

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     start     = 1'b0;
  logic                     opcode    = OP_GET;
  logic signed [WORD_W-1:0] key       = '0;
  logic signed [WORD_W-1:0] value     = '0;
  logic                     cfg_we    = 1'b0;
  logic [CAP_W-1:0]         cfg_wdata = '0;
  logic                     busy;
  logic                     result_strobe;
  logic                     found;
  logic signed [WORD_W-1:0] read_value;

  lru_mirror   mirror = new();
  int unsigned idle_pct = 24;
  int unsigned cap_writes = 0;
  int unsigned cycles = 0;

  lru_key_value_cache_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .key           (key),
    .value         (value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .result_strobe (result_strobe),
    .found         (found),
    .read_value    (read_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) mirror.check_answer(found, read_value);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_item(logic op, logic [WORD_W-1:0] k, logic [WORD_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // count only cycles in which the block could have taken a word
      repeat ($urandom_range(1, MAX_GAP)) begin
        do @(posedge clk); while (busy);
      end
    end
    start  <= 1'b1;
    opcode <= op;
    key    <= k;
    value  <= v;
    do @(posedge clk); while (busy);
    mirror.note_request(op, k, v);
  endtask

  // Drain everything in flight, then write the capacity register.
  task automatic set_capacity(logic [CAP_W-1:0] c);
    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    mirror.capacity = c;
    cfg_we <= 1'b0;
    cap_writes++;
  endtask

  function automatic logic [WORD_W-1:0] edge_word();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic run_phase(logic [CAP_W-1:0] c, int unsigned n, int unsigned idle);
    logic [WORD_W-1:0] pool[$];
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] v;
    logic              op;
    int unsigned       span;
    set_capacity(c);
    idle_pct = idle;
    // Keep the key pool a little larger than the capacity so hits and evictions mix.
    span = mirror.usable() + $urandom_range(1, 5);
    for (int i = 0; i < span; i++)
      pool.push_back(($urandom_range(7) == 0) ? edge_word() : $urandom);
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(99) < 50) ? OP_PUT : OP_GET;
      k  = ($urandom_range(99) < 85) ? pool[$urandom_range(span - 1)] : $urandom;
      v  = ($urandom_range(9) == 0) ? edge_word() : $urandom;
      send_item(op, k, v);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty cache, extreme keys and values, update in place, stored -1 vs miss.
    send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

    // Capacity zero acts as one and sits below the fill count: evict, never grow.
    set_capacity(5'd0);
    send_item(OP_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
    send_item(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);

    // Capacity above the maximum clamps to the maximum.
    set_capacity(5'd31);
    for (int i = 0; i < 5; i++) send_item(OP_PUT, 32'h0001_0000 + i, $urandom);
    send_item(OP_GET, 32'h0001_0002, 32'h0000_0000);

    run_phase(5'd1,  PHASE_ITEMS, 24);
    run_phase(5'd16, PHASE_ITEMS, 24);
    run_phase(5'd0,  PHASE_ITEMS, 24);
    run_phase(5'd31, PHASE_ITEMS, 24);
    run_phase(5'd2,  PHASE_ITEMS, 24);
    run_phase(5'd16, PHASE_ITEMS, 0);
    run_phase(5'd5,  PHASE_ITEMS, 24);
    run_phase(5'd8,  PHASE_ITEMS, 24);
    run_phase(5'($urandom_range(31)), PHASE_ITEMS, 24);
    run_phase(5'd3,  PHASE_ITEMS, 24);

    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d gets (%0d hits), %0d puts, %0d evictions",
             mirror.gets, mirror.hits, mirror.puts, mirror.evictions);
    $display("across %0d capacity writes, %0d mismatches", cap_writes, mirror.errors);
    if (mirror.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### lru_key_value_cache_top.f
hdl/lkv_pkg.sv
hdl/lkv_ram.sv
hdl/lru_key_value_cache_top.sv
test/tb_lru_key_value_cache_top.sv
